// File: hw/rtl/ckm_pkg.sv
// Shared widths, types and register codes for the chroma key mask.
`default_nettype none
package ckm_pkg;

    localparam int PIX_W          = 8;
    localparam int KEY_W          = 24;
    localparam int THR_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int DIST_FRAC_DEF  = 4;
    localparam int COMP_W         = 16;   // key/pixel components, 8 fraction bits
    localparam int DIFF_W         = 18;   // signed component difference
    localparam int S_W            = 34;   // sum of squares
    localparam int ROOT_W         = S_W / 2;
    localparam int REM_W          = ROOT_W + 2;
    localparam int SQRT_CELLS     = ROOT_W;
    localparam int DIV_STEPS      = 8;
    localparam int NUM_W          = THR_W + DIV_STEPS;
    localparam int FRONT_STAGES   = 4;
    localparam int PIPE_DEPTH     = FRONT_STAGES + SQRT_CELLS + 1 + DIV_STEPS + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_COLOR = 2'd0,
        CFG_INNER     = 2'd1,
        CFG_OUTER     = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [S_W-1:0]    s;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_dat_t;

    typedef struct packed {
        logic lt;   // below inner threshold
        logic gt;   // above outer threshold
        logic eq;   // thresholds equal
    } mask_flags_t;

    typedef struct packed {
        logic [NUM_W-1:0]     rem;
        logic [THR_W-1:0]     den;
        logic [DIV_STEPS-1:0] q;
        mask_flags_t          flags;
    } div_dat_t;

endpackage
`default_nettype wire

// File: hw/rtl/ckm_sqrt_cell.sv
// One root bit of the integer square root chain.
`default_nettype none
module ckm_sqrt_cell (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  ckm_pkg::sqrt_dat_t in_dat,
    output logic              out_valid,
    input  wire               out_ready,
    output ckm_pkg::sqrt_dat_t out_dat
);
    import ckm_pkg::*;

    logic               v_reg;
    sqrt_dat_t          dat_reg, dat_next;
    logic [REM_W+1:0]   acc;
    logic [REM_W+1:0]   trial;
    logic               en;

    assign en = !v_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        acc   = {in_dat.rem, in_dat.s[S_W-1 -: 2]};
        trial = (REM_W+2)'({in_dat.root, 2'b01});
        dat_next.s = {in_dat.s[S_W-3:0], 2'b00};
        if (acc >= trial)
        begin
            dat_next.rem  = REM_W'(acc - trial);
            dat_next.root = {in_dat.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            dat_next.rem  = REM_W'(acc);
            dat_next.root = {in_dat.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            dat_reg <= dat_next;
    end

    assign out_valid = v_reg;
    assign out_dat   = dat_reg;
endmodule
`default_nettype wire

// File: hw/rtl/ckm_div_cell.sv
// One quotient bit of the restoring divider chain.
`default_nettype none
module ckm_div_cell #(
    parameter int STEP = 0
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  ckm_pkg::div_dat_t in_dat,
    output logic             out_valid,
    input  wire              out_ready,
    output ckm_pkg::div_dat_t out_dat
);
    import ckm_pkg::*;

    logic             v_reg;
    div_dat_t         dat_reg, dat_next;
    logic [NUM_W-1:0] sub;
    logic             en;

    assign en = !v_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        sub = NUM_W'(in_dat.den) << STEP;
        dat_next = in_dat;
        if (in_dat.rem >= sub)
        begin
            dat_next.rem = in_dat.rem - sub;
            dat_next.q   = {in_dat.q[DIV_STEPS-2:0], 1'b1};
        end
        else
        begin
            dat_next.q   = {in_dat.q[DIV_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            dat_reg <= dat_next;
    end

    assign out_valid = v_reg;
    assign out_dat   = dat_reg;
endmodule
`default_nettype wire

// File: hw/rtl/chroma_key_mask.sv
// Top level of the chroma key soft mask pipeline.
// One pixel per clock enters while the output is not stalled, and one mask byte per pixel
// leaves, in order, after passing through four stages of color conversion and squaring,
// a chain of 17 square-root cells (one root bit each), a threshold stage, a chain of 8
// divider cells (one quotient bit each) and the output register. Every stage holds
// its item only while the next stage is full, so a stalled output fills the pipeline
// before s_tready drops. Registers are written through the cfg channel, which is always
// ready; they are read live, so write them only with the pipeline empty.
`default_nettype none
module chroma_key_mask #(
    parameter int DIST_FRAC_BITS = ckm_pkg::DIST_FRAC_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [3*ckm_pkg::PIX_W-1:0]   s_tdata,   // pix_blue, pix_green, pix_red
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [ckm_pkg::PIX_W-1:0]     m_tdata,   // mask_value
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [ckm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [ckm_pkg::KEY_W-1:0]     cfg_data
);
    import ckm_pkg::*;

    localparam int DW = ROOT_W - (8 - DIST_FRAC_BITS);
    localparam int CW = (DW > THR_W) ? DW : THR_W;

    // configuration
    logic [KEY_W-1:0] key_reg;
    logic [THR_W-1:0] inner_reg, outer_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= KEY_W'(24'h00FF00);
            inner_reg <= THR_W'(1600);
            outer_reg <= THR_W'(2720);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEY_COLOR: key_reg   <= cfg_data;
                CFG_INNER:     inner_reg <= cfg_data[THR_W-1:0];
                CFG_OUTER:     outer_reg <= cfg_data[THR_W-1:0];
                default:       ;
            endcase
        end
    end

    // stage enables, back to front
    logic v1_reg, v2_reg, v3_reg, v4_reg, vc_reg, vo_reg;
    logic en1, en2, en3, en4, enc, eno;
    logic [SQRT_CELLS:0] sq_valid, sq_ready;
    sqrt_dat_t           sq_dat [SQRT_CELLS+1];
    logic [DIV_STEPS:0]  dv_valid, dv_ready;
    div_dat_t            dv_dat [DIV_STEPS+1];

    assign eno = !vo_reg || m_tready;
    assign enc = !vc_reg || dv_ready[0];
    assign en4 = !v4_reg || sq_ready[0];
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    // stage 1: luma and key components
    logic [PIX_W-1:0] pb, pg, pr, kb, kg, kr;
    logic [21:0]        ysum;
    logic [23:0]        kysum;
    logic signed [25:0] kcrs, kcbs;
    logic [PIX_W-1:0]   y1_reg, pr1_reg, pb1_reg;
    logic [COMP_W-1:0]  ky1_reg, kcr1_reg, kcb1_reg;

    always_comb
    begin
        pb = s_tdata[7:0];
        pg = s_tdata[15:8];
        pr = s_tdata[23:16];
        kb = key_reg[7:0];
        kg = key_reg[15:8];
        kr = key_reg[23:16];
        ysum  = 22'(pr) * 22'd4899 + 22'(pg) * 22'd9617 + 22'(pb) * 22'd1868 + 22'd8192;
        kysum = 24'(kr) * 24'd16829 + 24'(kg) * 24'd33039 + 24'(kb) * 24'd6416 + 24'd128;
        kcrs  = 26'sd8388736 + $signed(26'(kr)) * 26'sd28784
              - $signed(26'(kg)) * 26'sd24103 - $signed(26'(kb)) * 26'sd4681;
        kcbs  = 26'sd8388736 - $signed(26'(kr)) * 26'sd9714
              - $signed(26'(kg)) * 26'sd19070 + $signed(26'(kb)) * 26'sd28784;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && s_tvalid)
        begin
            y1_reg   <= ysum[21:14];
            pr1_reg  <= pr;
            pb1_reg  <= pb;
            ky1_reg  <= kysum[23:8] + 16'd4096;
            kcr1_reg <= kcrs[23:8];
            kcb1_reg <= kcbs[23:8];
        end
    end

    // stage 2: chroma with clamp, then differences to the key
    logic signed [8:0]        ry, by;
    logic signed [24:0]       crv, cbv;
    logic [PIX_W-1:0]         cr, cb;
    logic signed [DIFF_W-1:0] dy2_reg, dcr2_reg, dcb2_reg;

    always_comb
    begin
        ry  = $signed({1'b0, pr1_reg}) - $signed({1'b0, y1_reg});
        by  = $signed({1'b0, pb1_reg}) - $signed({1'b0, y1_reg});
        crv = $signed({{16{ry[8]}}, ry}) * 25'sd11682 + 25'sd2105344;
        cbv = $signed({{16{by[8]}}, by}) * 25'sd9241 + 25'sd2105344;
        if (crv < 0)
            cr = '0;
        else if (crv[24:14] > 11'd255)
            cr = '1;
        else
            cr = crv[21:14];
        if (cbv < 0)
            cb = '0;
        else if (cbv[24:14] > 11'd255)
            cb = '1;
        else
            cb = cbv[21:14];
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            dy2_reg  <= $signed({2'b00, y1_reg, 8'h00}) - $signed({2'b00, ky1_reg});
            dcr2_reg <= $signed({2'b00, cr, 8'h00}) - $signed({2'b00, kcr1_reg});
            dcb2_reg <= $signed({2'b00, cb, 8'h00}) - $signed({2'b00, kcb1_reg});
        end
    end

    // stage 3: squares; stage 4: sum
    logic signed [2*DIFF_W-1:0] py, pcr, pcb;
    logic [S_W-1:0] py3_reg, pcr3_reg, pcb3_reg, sum4_reg;

    assign py  = dy2_reg * dy2_reg;
    assign pcr = dcr2_reg * dcr2_reg;
    assign pcb = dcb2_reg * dcb2_reg;

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            py3_reg  <= py[S_W-1:0];
            pcr3_reg <= pcr[S_W-1:0];
            pcb3_reg <= pcb[S_W-1:0];
        end
        if (en4 && v3_reg)
            sum4_reg <= py3_reg + pcr3_reg + pcb3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vc_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (enc) vc_reg <= sq_valid[SQRT_CELLS];
            if (eno) vo_reg <= dv_valid[DIV_STEPS];
        end
    end

    // square root chain
    assign sq_valid[0]       = v4_reg;
    assign sq_dat[0]         = {sum4_reg, REM_W'(0), ROOT_W'(0)};
    assign sq_ready[SQRT_CELLS] = enc;

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_sqrt
        ckm_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[i]),
            .in_ready  (sq_ready[i]),
            .in_dat    (sq_dat[i]),
            .out_valid (sq_valid[i+1]),
            .out_ready (sq_ready[i+1]),
            .out_dat   (sq_dat[i+1])
        );
    end

    // threshold stage
    logic [DW-1:0]    root_dist;
    logic [CW-1:0]    dist_w, inner_w, outer_w, diff_w;
    div_dat_t         cmp_next, cmp_reg;

    always_comb
    begin
        root_dist = sq_dat[SQRT_CELLS].root[ROOT_W-1 -: DW];
        dist_w  = CW'(root_dist);
        inner_w = CW'(inner_reg);
        outer_w = CW'(outer_reg);
        diff_w  = dist_w - inner_w;
        cmp_next.flags.lt = dist_w < inner_w;
        cmp_next.flags.gt = dist_w > outer_w;
        cmp_next.flags.eq = inner_reg == outer_reg;
        cmp_next.rem = NUM_W'(diff_w[THR_W-1:0]) * NUM_W'(255);
        cmp_next.den = outer_reg - inner_reg;
        cmp_next.q   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (enc && sq_valid[SQRT_CELLS])
            cmp_reg <= cmp_next;
    end

    // divider chain
    assign dv_valid[0] = vc_reg;
    assign dv_dat[0]   = cmp_reg;
    assign dv_ready[DIV_STEPS] = eno;

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        ckm_div_cell #(
            .STEP (DIV_STEPS - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[j]),
            .in_ready  (dv_ready[j]),
            .in_dat    (dv_dat[j]),
            .out_valid (dv_valid[j+1]),
            .out_ready (dv_ready[j+1]),
            .out_dat   (dv_dat[j+1])
        );
    end

    // output stage
    mask_flags_t      fl;
    logic [PIX_W-1:0] mask_next, mask_reg;

    always_comb
    begin
        fl = dv_dat[DIV_STEPS].flags;
        if (fl.lt)
            mask_next = '0;
        else if (fl.gt)
            mask_next = '1;
        else if (fl.eq)
            mask_next = '0;
        else
            mask_next = dv_dat[DIV_STEPS].q;
    end

    always_ff @(posedge clk)
    begin
        if (eno && dv_valid[DIV_STEPS])
            mask_reg <= mask_next;
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = mask_reg;
endmodule
`default_nettype wire

// File: hw/rtl/ckm_checker.sv
// Port-level checker for the chroma key mask, bound to the top level.
`default_nettype none
module ckm_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [ckm_pkg::PIX_W-1:0]      m_tdata
);
    import ckm_pkg::*;

    logic [5:0] cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (s_tvalid && s_tready)
            cnt_next = cnt_next + 6'd1;
        if (m_tvalid && m_tready)
            cnt_next = cnt_next - 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output item changed");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back pressure");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cnt_reg != 6'd0)
        else $error("output item without an accepted input item");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 6'(PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");
endmodule

bind chroma_key_mask ckm_checker u_ckm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
